// File: src/bmdc_pkg.sv
// ----------------------------------------------------------------------------
// bmdc_pkg
// Types and constants shared by the button mouse delta controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bmdc_pkg;

  localparam int unsigned HOLD_W  = 10;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned SETTLE_W = 6;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned DELTA_W = 5;
  localparam int unsigned NUM_BTN = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [HOLD_W-1:0]   HOLD_INTERVAL_RST = 10'd500;
  localparam logic [LIMIT_W-1:0]  DELTA_LIMIT_RST   = 4'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST  = 6'd30;
  localparam logic [PHASE_W-1:0]  PHASE_STEP_RST    = 32'd683565;

  localparam logic [HOLD_W-1:0] CNT_MAX = '1;
  localparam logic signed [DELTA_W:0] DELTA_MAX = 6'sd11;

  // angle boundaries where |4 sin| reaches 1..4, over a quarter turn
  localparam logic [30:0] SIN_BOUND [4] = '{
    31'd172723449, 31'd357913942, 31'd579705789, 31'd1073741824
  };
  localparam logic [30:0] QUARTER = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_INTERVAL = 2'd0,
    REG_DELTA_LIMIT   = 2'd1,
    REG_SETTLE_TICKS  = 2'd2,
    REG_PHASE_STEP    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              held;
    logic [HOLD_W-1:0] cnt;
    logic [DELTA_W-1:0] axis;
  } btn_res_t;

endpackage

`default_nettype wire

// File: src/button_mouse_delta_controller.sv
// ----------------------------------------------------------------------------
// button_mouse_delta_controller
// Per-tick cursor delta generator from five active-low buttons, with a
// manual stepping mode and a circle mode driven by a phase accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per 1 ms tick: the five button levels.
//   m_axis returns one word per tick: move_x, move_y and circle_mode.
//   cfg_we/cfg_index/cfg_data write hold_interval, delta_limit, settle_ticks
//   and phase_step; write them only while no word is in flight.
// Timing: a result appears in the output register in the cycle after its
//   input word is taken. Throughput: one word per cycle while the output
//   is taken; the whole update is one pass of combinational logic from
//   input word and state into the state and output registers.
// Stall: the output register holds its word until m_axis_tready; a new
//   input word is taken in the same cycle the held one leaves, so the
//   block keeps full rate under a ready receiver and stops only while the
//   output register is full and not taken.
// Reset: rst clears mode (manual), deltas, hold state, mode button state
//   and the phase accumulator, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_mouse_delta_controller (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [0] up_level, [1] down_level, [2] left_level, [3] right_level,
  // [4] mode_level, [7:5] zero
  input  wire logic [7:0]                          s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [4:0] move_x, [9:5] move_y, [15:10] zero
  output logic [15:0]                              m_axis_tdata,
  // [0] circle_mode
  output logic                                     m_axis_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [bmdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bmdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import bmdc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HELD,
    PH_SETTLE
  } mode_phase_t;

  logic [HOLD_W-1:0]   hold_interval;
  logic [LIMIT_W-1:0]  delta_limit;
  logic [SETTLE_W-1:0] settle_ticks;
  logic [PHASE_W-1:0]  phase_step;

  mode_phase_t          mode_phase, mode_phase_next;
  logic                 mode_flag, mode_flag_next;
  logic [NUM_BTN-1:0]   held_flags, held_flags_next;
  logic [HOLD_W-1:0]    hold_counters [NUM_BTN];
  logic [HOLD_W-1:0]    hold_counters_next [NUM_BTN];
  logic [DELTA_W-1:0]   delta_x, delta_x_next;
  logic [DELTA_W-1:0]   delta_y, delta_y_next;
  logic [SETTLE_W-1:0]  settle_count, settle_count_next;
  logic [PHASE_W-1:0]   circle_phase, circle_phase_next;

  logic                 accept;
  logic                 released;
  logic                 run;
  logic                 toggle;
  logic [PHASE_W-1:0]   phase_work;
  logic [DELTA_W-1:0]   x_work, y_work;
  btn_res_t             btn_res [NUM_BTN];

  function automatic logic [DELTA_W-1:0] sat_step(logic [DELTA_W-1:0] axis, logic neg);
    logic signed [DELTA_W:0] s;
    s = $signed({axis[DELTA_W-1], axis});
    s = neg ? s - 6'sd1 : s + 6'sd1;
    if (s > DELTA_MAX) s = DELTA_MAX;
    if (s < -DELTA_MAX) s = -DELTA_MAX;
    return s[DELTA_W-1:0];
  endfunction

  function automatic btn_res_t step_button(
    logic pressed, logic held, logic [HOLD_W-1:0] cnt, logic [DELTA_W-1:0] axis,
    logic neg, logic [LIMIT_W-1:0] lim, logic [HOLD_W-1:0] intv
  );
    btn_res_t r;
    logic signed [DELTA_W:0] a6;
    logic signed [DELTA_W:0] l6;
    logic inside_lim;
    a6 = $signed({axis[DELTA_W-1], axis});
    l6 = $signed({2'b00, lim});
    inside_lim = neg ? (a6 > -l6) : (a6 < l6);
    r.held = held;
    r.cnt  = cnt;
    r.axis = axis;
    if (pressed && !held) begin
      r.axis = sat_step(axis, neg);
      r.held = 1'b1;
      r.cnt  = '0;
    end else if (pressed) begin
      if (cnt >= intv && inside_lim) begin
        r.axis = sat_step(axis, neg);
        r.cnt  = '0;
      end else begin
        r.cnt = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
      end
    end else if (held) begin
      r.axis = '0;
      r.held = 1'b0;
      r.cnt  = '0;
    end
    return r;
  endfunction

  function automatic logic [DELTA_W-1:0] four_sin(logic [PHASE_W-1:0] p);
    logic [30:0] d;
    logic [2:0]  m;
    d = p[30] ? QUARTER - {1'b0, p[29:0]} : {1'b0, p[29:0]};
    m = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (d >= SIN_BOUND[k]) m = m + 3'd1;
    end
    return p[31] ? DELTA_W'(-$signed({2'b00, m})) : {2'b00, m};
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign released      = s_axis_tdata[4];

  always_comb begin
    mode_phase_next   = mode_phase;
    settle_count_next = settle_count;
    run    = 1'b0;
    toggle = 1'b0;
    unique case (mode_phase)
      PH_HELD: begin
        if (released) begin
          if (settle_ticks == '0) begin
            toggle          = 1'b1;
            mode_phase_next = PH_IDLE;
            run             = 1'b1;
          end else begin
            settle_count_next = settle_ticks;
            mode_phase_next   = PH_SETTLE;
          end
        end
      end
      PH_SETTLE: begin
        if (settle_count <= SETTLE_W'(1)) begin
          settle_count_next = '0;
          toggle            = released;
          mode_phase_next   = PH_IDLE;
          run               = 1'b1;
        end else begin
          settle_count_next = settle_count - 1'b1;
        end
      end
      default: begin
        if (!released) mode_phase_next = PH_HELD;
        else run = 1'b1;
      end
    endcase

    mode_flag_next = toggle ? !mode_flag : mode_flag;
    x_work     = toggle ? '0 : delta_x;
    y_work     = toggle ? '0 : delta_y;
    phase_work = (toggle && !mode_flag) ? '0 : circle_phase;

    btn_res[0] = step_button(!s_axis_tdata[0], held_flags[0], hold_counters[0], y_work,
                             1'b1, delta_limit, hold_interval);
    btn_res[1] = step_button(!s_axis_tdata[1], held_flags[1], hold_counters[1],
                             btn_res[0].axis, 1'b0, delta_limit, hold_interval);
    btn_res[2] = step_button(!s_axis_tdata[2], held_flags[2], hold_counters[2], x_work,
                             1'b1, delta_limit, hold_interval);
    btn_res[3] = step_button(!s_axis_tdata[3], held_flags[3], hold_counters[3],
                             btn_res[2].axis, 1'b0, delta_limit, hold_interval);

    held_flags_next   = held_flags;
    circle_phase_next = phase_work;
    delta_x_next      = x_work;
    delta_y_next      = y_work;
    for (int i = 0; i < NUM_BTN; i++) begin
      hold_counters_next[i] = hold_counters[i];
    end

    if (run && !mode_flag_next) begin
      for (int i = 0; i < NUM_BTN; i++) begin
        held_flags_next[i]    = btn_res[i].held;
        hold_counters_next[i] = btn_res[i].cnt;
      end
      delta_y_next = btn_res[1].axis;
      delta_x_next = btn_res[3].axis;
    end else begin
      for (int i = 0; i < NUM_BTN; i++) begin
        if (held_flags[i] && hold_counters[i] != CNT_MAX) begin
          hold_counters_next[i] = hold_counters[i] + 1'b1;
        end
      end
      if (mode_flag_next) begin
        if (run) begin
          delta_x_next = four_sin(phase_work);
          delta_y_next = four_sin({phase_work[31:30] + 2'd1, phase_work[29:0]});
        end
        circle_phase_next = phase_work + phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_interval <= HOLD_INTERVAL_RST;
      delta_limit   <= DELTA_LIMIT_RST;
      settle_ticks  <= SETTLE_TICKS_RST;
      phase_step    <= PHASE_STEP_RST;
      mode_phase    <= PH_IDLE;
      mode_flag     <= 1'b0;
      held_flags    <= '0;
      for (int i = 0; i < NUM_BTN; i++) hold_counters[i] <= '0;
      delta_x       <= '0;
      delta_y       <= '0;
      settle_count  <= '0;
      circle_phase  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_HOLD_INTERVAL: hold_interval <= cfg_data[HOLD_W-1:0];
          REG_DELTA_LIMIT:   delta_limit   <= cfg_data[LIMIT_W-1:0];
          REG_SETTLE_TICKS:  settle_ticks  <= cfg_data[SETTLE_W-1:0];
          REG_PHASE_STEP:    phase_step    <= cfg_data[PHASE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        mode_phase   <= mode_phase_next;
        mode_flag    <= mode_flag_next;
        held_flags   <= held_flags_next;
        for (int i = 0; i < NUM_BTN; i++) hold_counters[i] <= hold_counters_next[i];
        delta_x      <= delta_x_next;
        delta_y      <= delta_y_next;
        settle_count <= settle_count_next;
        circle_phase <= circle_phase_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {6'b0, delta_y, delta_x};
  assign m_axis_tuser = mode_flag;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_delta_x_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(delta_x) <= 5'sd11) && ($signed(delta_x) >= -5'sd11))
    else $error("delta_x out of range");

  a_delta_y_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(delta_y) <= 5'sd11) && ($signed(delta_y) >= -5'sd11))
    else $error("delta_y out of range");

  a_settle_idle: assert property (@(posedge clk) disable iff (rst)
    (mode_phase != PH_SETTLE) |-> (settle_count == '0))
    else $error("settle count live outside settling");

  a_circle_keeps_held: assert property (@(posedge clk) disable iff (rst)
    (accept && mode_flag && mode_flag_next) |=> $stable(held_flags))
    else $error("held flags changed in circle mode");

endmodule

`default_nettype wire

// File: tb/sv/button_mouse_delta_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_mouse_delta_controller_tb
// Streams 1 ms button ticks into the controller and checks every result word
// (move_x, move_y, circle_mode) against an in-bench predictor of the manual
// stepping, mode button debounce and circle phase logic. Runs a directed
// opener, then random press, hold, release and mode toggle sequences over
// several register settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module button_mouse_delta_controller_tb;
  import bmdc_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [4:0] BTN_UP    = 5'b00001;
  localparam logic [4:0] BTN_DOWN  = 5'b00010;
  localparam logic [4:0] BTN_LEFT  = 5'b00100;
  localparam logic [4:0] BTN_RIGHT = 5'b01000;
  localparam logic [4:0] BTN_MODE  = 5'b10000;
  localparam logic [4:0] BTN_DIRS  = 5'b01111;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [1:0] {MB_IDLE, MB_HELD, MB_SETTLE} mode_btn_t;

  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic       circle;
  } mouse_delta_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_HOLD_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadows
  logic [9:0]  cfg_hold   = HOLD_INTERVAL_RST;
  logic [3:0]  cfg_limit  = DELTA_LIMIT_RST;
  logic [5:0]  cfg_settle = SETTLE_TICKS_RST;
  logic [31:0] cfg_step   = PHASE_STEP_RST;

  // predicted block state
  bit          circle_on = 1'b0;
  bit          held [4];
  logic [9:0]  hold_cnt [4];
  int          dx = 0;
  int          dy = 0;
  mode_btn_t   mb_state = MB_IDLE;
  logic [5:0]  settle_left = '0;
  logic [31:0] phase_acc = '0;

  logic [4:0]   tick_q [$];
  mouse_delta_t want_deltas [$];
  mouse_delta_t got, want;
  int  ticks_queued = 0;
  int  ticks_in = 0;
  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 7;
  int  recv_idle = 60;
  bit  in_fire = 1'b0;

  button_mouse_delta_controller DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int sat11(int v);
    if (v > 11) return 11;
    if (v < -11) return -11;
    return v;
  endfunction

  function automatic logic [9:0] bump(logic [9:0] c);
    return (c == 10'h3FF) ? c : c + 10'd1;
  endfunction

  function automatic int four_sin(logic [31:0] p);
    logic [31:0] d;
    int m;
    d = p[30] ? (QUARTER_TURN - {2'b00, p[29:0]}) : {2'b00, p[29:0]};
    m = int'(d >= 32'd172723449) + int'(d >= 32'd357913942) +
        int'(d >= 32'd579705789) + int'(d >= 32'd1073741824);
    return p[31] ? -m : m;
  endfunction

  task automatic step_button(input int i, input bit pressed, inout int axis,
                             input int dir);
    bit room;
    room = (dir < 0) ? (axis > -int'(cfg_limit)) : (axis < int'(cfg_limit));
    if (pressed && !held[i]) begin
      axis = sat11(axis + dir);
      held[i] = 1'b1;
      hold_cnt[i] = '0;
    end else if (pressed) begin
      if (hold_cnt[i] >= cfg_hold && room) begin
        axis = sat11(axis + dir);
        hold_cnt[i] = '0;
      end else begin
        hold_cnt[i] = bump(hold_cnt[i]);
      end
    end else if (held[i]) begin
      axis = 0;
      held[i] = 1'b0;
      hold_cnt[i] = '0;
    end
  endtask

  task automatic toggle_mode();
    circle_on = !circle_on;
    dx = 0;
    dy = 0;
    if (circle_on) phase_acc = '0;
  endtask

  task automatic advance_mouse(input logic [4:0] lv, output mouse_delta_t r);
    bit released;
    bit run;
    released = lv[4];
    run = 1'b0;
    case (mb_state)
      MB_HELD: begin
        if (released) begin
          if (cfg_settle == 0) begin
            toggle_mode();
            mb_state = MB_IDLE;
            run = 1'b1;
          end else begin
            settle_left = cfg_settle;
            mb_state = MB_SETTLE;
          end
        end
      end
      MB_SETTLE: begin
        if (settle_left <= 1) begin
          settle_left = '0;
          if (released) toggle_mode();
          mb_state = MB_IDLE;
          run = 1'b1;
        end else begin
          settle_left = settle_left - 6'd1;
        end
      end
      default: begin
        if (!released) mb_state = MB_HELD;
        else run = 1'b1;
      end
    endcase
    if (run && !circle_on) begin
      step_button(0, !lv[0], dy, -1);
      step_button(1, !lv[1], dy, 1);
      step_button(2, !lv[2], dx, -1);
      step_button(3, !lv[3], dx, 1);
    end else begin
      for (int i = 0; i < 4; i++)
        if (held[i]) hold_cnt[i] = bump(hold_cnt[i]);
      if (circle_on) begin
        if (run) begin
          dx = four_sin(phase_acc);
          dy = four_sin(phase_acc + QUARTER_TURN);
        end
        phase_acc = phase_acc + cfg_step;
      end
    end
    r.x = dx[4:0];
    r.y = dy[4:0];
    r.circle = circle_on;
  endtask

  // driver: change inputs on the falling edge
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tdata <= {3'b000, tick_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("button_mouse_delta_controller test failed");
      $finish;
    end else begin
      in_fire = !rst && s_axis_tvalid && s_axis_tready;
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[4:0];
        got.y = m_axis_tdata[9:5];
        got.circle = m_axis_tuser;
        if (want_deltas.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d circle=%0d", $time,
                   $signed(got.x), $signed(got.y), got.circle);
          errors++;
        end else begin
          want = want_deltas.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: move_x expected %0d actual %0d", $time,
                     $signed(want.x), $signed(got.x));
            errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: move_y expected %0d actual %0d", $time,
                     $signed(want.y), $signed(got.y));
            errors++;
          end
          if (got.circle !== want.circle) begin
            $display("%0t: circle_mode expected %0d actual %0d", $time,
                     want.circle, got.circle);
            errors++;
          end
        end
      end
      if (in_fire) begin
        advance_mouse(s_axis_tdata[4:0], want);
        want_deltas.push_back(want);
        ticks_in++;
      end
    end
  end

  task automatic hold_ticks(input logic [4:0] pressed, input int n);
    repeat (n) begin
      tick_q.push_back(~pressed);
      ticks_queued++;
    end
  endtask

  task automatic wait_idle();
    while (ticks_in != ticks_queued || want_deltas.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HOLD_INTERVAL: cfg_hold = val[9:0];
      REG_DELTA_LIMIT:   cfg_limit = val[3:0];
      REG_SETTLE_TICKS:  cfg_settle = val[5:0];
      default:           cfg_step = val;
    endcase
  endtask

  task automatic write_all(input logic [31:0] h, input logic [31:0] l,
                           input logic [31:0] s, input logic [31:0] p);
    wait_idle();
    write_reg(REG_HOLD_INTERVAL, h);
    write_reg(REG_DELTA_LIMIT, l);
    write_reg(REG_SETTLE_TICKS, s);
    write_reg(REG_PHASE_STEP, p);
  endtask

  task automatic run_random(input int n);
    int start;
    int r;
    logic [4:0] dirs;
    start = ticks_queued;
    while (ticks_queued - start < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        if ($urandom_range(1) == 1) dirs = 5'b00001 << $urandom_range(3);
        else dirs = 5'($urandom_range(1, 15));
        if ($urandom_range(9) == 0) hold_ticks(dirs, $urandom_range(20, 60));
        else hold_ticks(dirs, $urandom_range(1, 12));
        hold_ticks(5'b00000, $urandom_range(1, 3));
      end else if (r < 80) begin
        if ($urandom_range(2) == 0)
          hold_ticks(BTN_MODE | 5'($urandom_range(15)), $urandom_range(1, 3));
        else
          hold_ticks(BTN_MODE, $urandom_range(1, 3));
        if ($urandom_range(3) != 0) begin
          hold_ticks(5'b00000, int'(cfg_settle) + $urandom_range(1, 4));
        end else begin
          hold_ticks(5'b00000, $urandom_range(0, int'(cfg_settle)));
          hold_ticks(BTN_MODE, 1);
        end
      end else begin
        repeat ($urandom_range(1, 4)) hold_ticks(5'($urandom_range(31)), 1);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      held[i] = 1'b0;
      hold_cnt[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: first press, no repeat, release, opposing pairs
    hold_ticks(BTN_UP, 2);
    hold_ticks(5'b00000, 1);
    hold_ticks(BTN_LEFT | BTN_RIGHT, 1);
    hold_ticks(BTN_UP | BTN_DOWN, 1);
    hold_ticks(5'b00000, 1);

    // fast repeat up to the limit, all buttons, mode toggle with no settle
    write_all(32'd1, 32'd2, 32'd0, 32'h1000_0000);
    hold_ticks(BTN_DOWN, 5);
    hold_ticks(BTN_DIRS, 1);
    hold_ticks(5'b00000, 1);
    hold_ticks(BTN_MODE, 1);
    hold_ticks(5'b00000, 1);
    hold_ticks(BTN_UP, 1);
    hold_ticks(5'b00000, 3);
    hold_ticks(BTN_MODE, 1);
    hold_ticks(5'b00000, 1);

    write_all(32'd3, 32'd10, 32'd2, 32'h0400_0000);
    run_random(140);
    write_all(32'd0, 32'd15, 32'd0, 32'hFFFF_FFFF);
    run_random(140);

    wait_idle();
    send_idle = 60;
    recv_idle = 7;
    write_all(32'd1023, 32'd1, 32'd63, 32'd0);
    run_random(140);
    write_all(32'd500, 32'd10, 32'd30, 32'd683565);
    run_random(140);

    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    write_all(32'd1, 32'd0, 32'd1, $urandom);
    run_random(140);
    write_all($urandom_range(0, 8), $urandom_range(0, 15), $urandom_range(0, 5), $urandom);
    run_random(140);

    wait_idle();
    repeat (3) @(negedge clk);
    if (errors == 0) begin
      $display("button_mouse_delta_controller test passed");
    end else begin
      $display("button_mouse_delta_controller test failed");
    end
    $finish;
  end

endmodule
